>>> sv/jcd_pkg.sv
// ----------------------------------------------------------------------------
// Julian calendar date unit package
// Shared types, constants and calendar helper functions.
// ----------------------------------------------------------------------------
package jcd_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DFIN,
		ST_DMON,
		ST_YADD,
		ST_MSTEP,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		CMD_SET   = 3'd0,
		CMD_LOAD  = 3'd1,
		CMD_YADD  = 3'd2,
		CMD_MADD  = 3'd3,
		CMD_QUERY = 3'd4
	} cmd_t;

	localparam logic [11:0] YearMin  = 12'd1858;
	localparam logic [11:0] YearMax  = 12'd2558;
	localparam logic [11:0] YearBase = 12'd1856;
	localparam logic [21:0] DayMin   = 22'd2399693;
	localparam logic [21:0] DayMax   = 22'd2655732;
	// Day number of March 1, 1856: the origin of the four-year cycles.
	localparam logic [21:0] DayBase  = 22'd2399022;
	localparam logic [17:0] CycleLen = 18'd1461;
	// Reciprocal of 7 scaled by 2^18, exact for values below 4096.
	localparam logic [27:0] Recip7   = 28'd37450;

	// First day of each month in a year that starts on March 1.
	localparam logic [8:0] MonStart [12] = '{
		9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
		9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
	};

	function automatic logic [4:0] month_days(logic [3:0] m, logic [11:0] y);
		logic [4:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			4'd2: r = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Day number of a valid date.
	function automatic logic [21:0] encode_date(logic [11:0] y, logic [3:0] m,
			logic [4:0] d);
		logic [11:0] yp;
		logic [3:0]  mp;
		logic [9:0]  yo;
		if (m <= 4'd2) begin
			yp = y - 12'd1;
			mp = m + 4'd9;
		end else begin
			yp = y;
			mp = m - 4'd3;
		end
		yo = 10'(yp - YearBase);
		return DayBase + 22'(yo) * 22'd365 + 22'(yo[9:2]) + 22'(MonStart[mp])
			+ 22'(d) - 22'd1;
	endfunction

endpackage

>>> sv/jcd_if.sv
// ----------------------------------------------------------------------------
// Julian calendar date unit channels
// Command channel and result channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface jcd_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [11:0]        set_year;
	logic [3:0]         set_month;
	logic [4:0]         set_day;
	logic [21:0]        load_day_number;
	logic signed [14:0] amount;

	modport source (output valid, cmd, set_year, set_month, set_day, load_day_number,
		amount, input ready);
	modport sink (input valid, cmd, set_year, set_month, set_day, load_day_number,
		amount, output ready);
endinterface

interface jcd_rsp_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [2:0]  weekday;
	logic [4:0]  days_in_month;
	logic [21:0] day_number;
	logic        error;

	modport source (output valid, year, month, day, weekday, days_in_month,
		day_number, error, input ready);
	modport sink (input valid, year, month, day, weekday, days_in_month,
		day_number, error, output ready);
endinterface

>>> sv/julian_calendar_date_unit.sv
// ----------------------------------------------------------------------------
// Julian calendar date unit
// Holds one date as a Julian day number and carries out one command per beat.
// ----------------------------------------------------------------------------
// Throughput: one command at a time; the next command beat is taken once the
// result beat has left. The date decode runs 8 steps on one compare-subtract
// unit, and a month add walks one month per cycle.
// Reset: the stored date becomes day 2399693 (January 1, 1858) and the unit idles.
module julian_calendar_date_unit (
	input  logic       clk,
	input  logic       arst_n,
	jcd_req_if.sink    req,
	jcd_rsp_if.source  rsp
);
	jcd_pkg::state_t state_q, state_d;

	// Latched command beat.
	logic [2:0]         cmd_q;
	logic [11:0]        sy_q;
	logic [3:0]         sm_q;
	logic [4:0]         sd_q;
	logic [21:0]        ld_q;
	logic signed [14:0] amt_q;

	// Stored date and status.
	logic [21:0] cur_q;
	logic        err_q;
	logic        final_q;

	// Decoder state: the remainder and quotient of the four-year cycle division.
	logic [17:0] rem_q;
	logic [7:0]  q4_q;
	logic [2:0]  bit_q;
	logic [1:0]  yi_q;
	logic [8:0]  doy_q;
	logic [11:0] x_q;
	logic [27:0] prod_q;

	// Broken-down date.
	logic [11:0] y_q;
	logic [3:0]  m_q;
	logic [4:0]  d_q;
	logic [2:0]  wk_q;
	logic [4:0]  dim_q;
	logic [14:0] cnt_q;

	// Sequencer outputs.
	logic in_rdy;
	logic out_vld;

	// Shared compare-subtract unit.
	logic [17:0] sub_b;
	logic        sub_ge;
	logic [17:0] sub_diff;

	assign sub_b = jcd_pkg::CycleLen << bit_q;

	jcd_sub_unit u_sub (
		.a    (rem_q),
		.b    (sub_b),
		.ge   (sub_ge),
		.diff (sub_diff)
	);

	// ---------------------------------------------------------------- execute
	// A set is accepted only for a valid date in the year span; a load only for
	// a day number in the span.
	logic        set_ok;
	logic        load_ok;
	logic [21:0] exec_cur;
	logic        exec_err;

	always_comb begin
		set_ok = (sy_q >= jcd_pkg::YearMin) && (sy_q <= jcd_pkg::YearMax)
			&& (sm_q >= 4'd1) && (sm_q <= 4'd12) && (sd_q != 5'd0)
			&& (sd_q <= jcd_pkg::month_days(sm_q, sy_q));
		load_ok = (ld_q >= jcd_pkg::DayMin) && (ld_q <= jcd_pkg::DayMax);
		exec_cur = cur_q;
		exec_err = 1'b0;
		case (cmd_q)
			jcd_pkg::CMD_SET: begin
				if (set_ok) exec_cur = jcd_pkg::encode_date(sy_q, sm_q, sd_q);
				else exec_err = 1'b1;
			end
			jcd_pkg::CMD_LOAD: begin
				if (load_ok) exec_cur = ld_q;
				else exec_err = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- decode
	// The remainder within the four-year cycle splits into year and day of year;
	// the day of year is then matched against the month starts.
	logic [10:0] r_cyc;
	logic [1:0]  yi_c;
	logic [8:0]  doy_c;
	logic [11:0] x_c;
	logic [3:0]  mp_c;
	logic [9:0]  q7_c;
	logic [2:0]  r7_c;
	logic [3:0]  wd_c;
	logic [3:0]  mon_c;
	logic [4:0]  day_c;
	logic [11:0] year_c;

	always_comb begin
		r_cyc = rem_q[10:0];
		if (r_cyc >= 11'd1095) begin
			yi_c  = 2'd3;
			doy_c = 9'(r_cyc - 11'd1095);
		end else if (r_cyc >= 11'd730) begin
			yi_c  = 2'd2;
			doy_c = 9'(r_cyc - 11'd730);
		end else if (r_cyc >= 11'd365) begin
			yi_c  = 2'd1;
			doy_c = 9'(r_cyc - 11'd365);
		end else begin
			yi_c  = 2'd0;
			doy_c = 9'(r_cyc);
		end
		// The cycle length leaves 5 modulo 7, so this sum has the remainder modulo 7 of the offset from the day base.
		x_c = 12'(q4_q) * 12'd5 + 12'(r_cyc);

		mp_c = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy_q >= jcd_pkg::MonStart[i]) mp_c = 4'(i);
		end
		day_c  = 5'(doy_q - jcd_pkg::MonStart[mp_c] + 9'd1);
		mon_c  = (mp_c < 4'd10) ? mp_c + 4'd3 : mp_c - 4'd9;
		year_c = jcd_pkg::YearBase + {2'b00, q4_q, 2'b00} + 12'(yi_q)
			+ 12'(mp_c >= 4'd10);

		// Day base is 3 modulo 7, and day number 0 modulo 7 is a Monday.
		q7_c = prod_q[27:18];
		r7_c = 3'(x_q - 12'(q7_c) * 12'd7);
		wd_c = 4'(r7_c) + 4'd3;
		if (wd_c >= 4'd7) wd_c = wd_c - 4'd7;
	end

	// ---------------------------------------------------------------- year add
	logic signed [15:0] ny_s;
	logic [4:0]         yd_c;
	logic               yadd_ok;

	always_comb begin
		ny_s    = $signed({4'b0000, y_q}) + 16'(amt_q);
		yadd_ok = (ny_s >= $signed({4'b0000, jcd_pkg::YearMin}))
			&& (ny_s <= $signed({4'b0000, jcd_pkg::YearMax}));
		yd_c = d_q;
		if ((m_q == 4'd2) && (d_q == 5'd29) && (ny_s[1:0] != 2'd0)) yd_c = 5'd28;
	end

	// ---------------------------------------------------------------- month add
	logic [11:0] my_c;
	logic [3:0]  mm_c;
	logic [4:0]  mlim_c;
	logic [4:0]  md_c;
	logic        mstep_ok;

	always_comb begin
		my_c = y_q;
		if (amt_q[14]) begin
			if (m_q == 4'd1) begin
				mm_c = 4'd12;
				my_c = y_q - 12'd1;
			end else begin
				mm_c = m_q - 4'd1;
			end
		end else begin
			if (m_q == 4'd12) begin
				mm_c = 4'd1;
				my_c = y_q + 12'd1;
			end else begin
				mm_c = m_q + 4'd1;
			end
		end
		mstep_ok = (my_c >= jcd_pkg::YearMin) && (my_c <= jcd_pkg::YearMax);
		mlim_c   = jcd_pkg::month_days(mm_c, my_c);
		md_c     = (d_q > mlim_c) ? mlim_c : d_q;
	end

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			jcd_pkg::ST_IDLE:  if (req.valid) state_d = jcd_pkg::ST_EXEC;
			jcd_pkg::ST_EXEC:  state_d = jcd_pkg::ST_DIV;
			jcd_pkg::ST_DIV:   if (bit_q == 3'd0) state_d = jcd_pkg::ST_DFIN;
			jcd_pkg::ST_DFIN:  state_d = jcd_pkg::ST_DMON;
			jcd_pkg::ST_DMON: begin
				if (final_q) state_d = jcd_pkg::ST_OUT;
				else if (cmd_q == jcd_pkg::CMD_YADD) state_d = jcd_pkg::ST_YADD;
				else state_d = jcd_pkg::ST_MSTEP;
			end
			jcd_pkg::ST_YADD:  state_d = jcd_pkg::ST_DIV;
			jcd_pkg::ST_MSTEP: begin
				if ((cnt_q == 15'd0) || !mstep_ok) state_d = jcd_pkg::ST_DIV;
			end
			jcd_pkg::ST_OUT:   if (rsp.ready) state_d = jcd_pkg::ST_IDLE;
			default:           state_d = jcd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_rdy  = 1'b0;
		out_vld = 1'b0;
		case (state_q)
			jcd_pkg::ST_IDLE: in_rdy  = 1'b1;
			jcd_pkg::ST_OUT:  out_vld = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jcd_pkg::ST_IDLE;
			cur_q   <= jcd_pkg::DayMin;
		end else begin
			state_q <= state_d;
			case (state_q)
				jcd_pkg::ST_EXEC: cur_q <= exec_cur;
				jcd_pkg::ST_YADD: begin
					if (yadd_ok) cur_q <= jcd_pkg::encode_date(ny_s[11:0], m_q, yd_c);
				end
				jcd_pkg::ST_MSTEP: begin
					if ((cnt_q == 15'd0) || !mstep_ok)
						cur_q <= jcd_pkg::encode_date(y_q, m_q, d_q);
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers; each state loads what it produces.
	always_ff @(posedge clk) begin
		case (state_q)
			jcd_pkg::ST_IDLE: begin
				cmd_q <= req.cmd;
				sy_q  <= req.set_year;
				sm_q  <= req.set_month;
				sd_q  <= req.set_day;
				ld_q  <= req.load_day_number;
				amt_q <= req.amount;
			end
			jcd_pkg::ST_EXEC: begin
				err_q   <= exec_err;
				final_q <= !((cmd_q == jcd_pkg::CMD_YADD) || (cmd_q == jcd_pkg::CMD_MADD));
				rem_q   <= 18'(exec_cur - jcd_pkg::DayBase);
				bit_q   <= 3'd7;
				cnt_q   <= amt_q[14] ? 15'(-amt_q) : 15'(amt_q);
			end
			jcd_pkg::ST_DIV: begin
				rem_q        <= sub_diff;
				q4_q[bit_q]  <= sub_ge;
				bit_q        <= bit_q - 3'd1;
			end
			jcd_pkg::ST_DFIN: begin
				yi_q   <= yi_c;
				doy_q  <= doy_c;
				x_q    <= x_c;
				prod_q <= 28'(x_c) * jcd_pkg::Recip7;
			end
			jcd_pkg::ST_DMON: begin
				y_q   <= year_c;
				m_q   <= mon_c;
				d_q   <= day_c;
				wk_q  <= 3'(wd_c + 4'd1);
				dim_q <= jcd_pkg::month_days(mon_c, year_c);
			end
			jcd_pkg::ST_YADD: begin
				final_q <= 1'b1;
				bit_q   <= 3'd7;
				if (yadd_ok) begin
					rem_q <= 18'(jcd_pkg::encode_date(ny_s[11:0], m_q, yd_c)
						- jcd_pkg::DayBase);
				end else begin
					err_q <= 1'b1;
					rem_q <= 18'(cur_q - jcd_pkg::DayBase);
				end
			end
			jcd_pkg::ST_MSTEP: begin
				if ((cnt_q == 15'd0) || !mstep_ok) begin
					// Stop here: keep the month reached so far.
					final_q <= 1'b1;
					bit_q   <= 3'd7;
					rem_q   <= 18'(jcd_pkg::encode_date(y_q, m_q, d_q) - jcd_pkg::DayBase);
					if (cnt_q != 15'd0) err_q <= 1'b1;
				end else begin
					y_q   <= my_c;
					m_q   <= mm_c;
					d_q   <= md_c;
					cnt_q <= cnt_q - 15'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready         = in_rdy;
	assign rsp.valid         = out_vld;
	assign rsp.year          = y_q;
	assign rsp.month         = m_q;
	assign rsp.day           = d_q;
	assign rsp.weekday       = wk_q;
	assign rsp.days_in_month = dim_q;
	assign rsp.day_number    = cur_q;
	assign rsp.error         = err_q;
endmodule

>>> sv/jcd_sub_unit.sv
// ----------------------------------------------------------------------------
// Julian calendar date unit compare-subtract stage
// One restoring division step: subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module jcd_sub_unit (
	input  logic [17:0] a,
	input  logic [17:0] b,
	output logic        ge,
	output logic [17:0] diff
);
	logic [18:0] d;

	assign d    = {1'b0, a} - {1'b0, b};
	assign ge   = ~d[18];
	assign diff = ge ? d[17:0] : a;
endmodule
